@@ src/cell_to_ansi_sgr_encoder_assert.svh @@
// Assertion macros shared by the encoder modules; they expect clk and arst_n in scope.
`ifndef CELL_TO_ANSI_SGR_ENCODER_ASSERT_SVH
`define CELL_TO_ANSI_SGR_ENCODER_ASSERT_SVH

// cond must hold at every edge out of reset
`define CSE_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// cons must follow ante, as a non-overlapping implication
`define CSE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/cse_pkg.sv @@
// Shared types, byte codes and helpers for the ANSI SGR cell encoder.
`timescale 1ns / 1ps
package cse_pkg;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);

	localparam logic [7:0] ESC_CHAR = 8'h1B;
	localparam logic [7:0] LBRACKET = 8'h5B;
	localparam logic [7:0] SEMI     = 8'h3B;
	localparam logic [7:0] SGR_END  = 8'h6D;
	localparam logic [7:0] BLANK    = 8'h20;
	localparam logic [7:0] ASCII_0  = 8'h30;
	localparam logic [7:0] ASCII_1  = 8'h31;
	localparam logic [7:0] ASCII_3  = 8'h33;
	localparam logic [7:0] ASCII_4  = 8'h34;
	localparam logic [7:0] ASCII_9  = 8'h39;

	// Classified cell request passed from front to back
	typedef struct packed {
		logic       esc;
		logic       bg_chg;
		logic       fg_chg;
		logic [3:0] bg;
		logic [3:0] fg;
		logic [7:0] ch;
	} cse_req_t;

	function automatic logic [7:0] digit_char(input logic [2:0] d);
		return ASCII_0 | {5'b0, d};
	endfunction

endpackage

@@ src/cse_front.sv @@
// Front end: accepts cells, decides which escape parts each needs, tracks colour state.
`timescale 1ns / 1ps
`include "cell_to_ansi_sgr_encoder_assert.svh"
module cse_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cell_valid,
	output logic              cell_stall,
	input  logic              frame_start,
	input  logic [7:0]        colour,
	input  logic [7:0]        character,
	input  logic              q_full,
	output logic              q_push,
	output cse_pkg::cse_req_t q_req
);
	import cse_pkg::*;

	logic       fresh_q;
	logic [7:0] prev_colour_q;
	logic [3:0] prev_bg_q;
	logic [3:0] prev_fg_q;

	logic       first;
	logic       esc;
	logic [3:0] bg;
	logic [3:0] fg;
	logic       bg_chg;
	logic       fg_chg;

	assign bg     = colour[7:4];
	assign fg     = colour[3:0];
	assign first  = frame_start | fresh_q;
	assign esc    = first | (colour != prev_colour_q);
	assign bg_chg = esc & (first | (bg != prev_bg_q));
	assign fg_chg = esc & (first | (fg != prev_fg_q));

	assign cell_stall = q_full;
	assign q_push     = cell_valid & ~q_full;

	always_comb begin
		q_req.esc    = esc;
		q_req.bg_chg = bg_chg;
		q_req.fg_chg = fg_chg;
		q_req.bg     = bg;
		q_req.fg     = fg;
		q_req.ch     = (character == 8'h00) ? BLANK : character;
	end

	// commit colour state as soon as the request is queued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q       <= 1'b1;
			prev_colour_q <= 8'h00;
			prev_bg_q     <= 4'h0;
			prev_fg_q     <= 4'h0;
		end else if (q_push) begin
			fresh_q <= 1'b0;
			if (esc) begin
				prev_colour_q <= colour;
			end
			if (bg_chg) begin
				prev_bg_q <= bg;
			end
			if (fg_chg) begin
				prev_fg_q <= fg;
			end
		end
	end

	`CSE_ASSERT_NEXT(a_fresh_clears, q_push, !fresh_q, "fresh frame flag survived a request")
	`CSE_ASSERT_NEXT(a_colour_tracks, q_push && esc,
		prev_colour_q[7:4] == prev_bg_q && prev_colour_q[3:0] == prev_fg_q,
		"stored nibbles diverged from stored colour")
	`CSE_ASSERT_ALWAYS(a_first_forces_both, !(q_push && first) || (esc && bg_chg && fg_chg),
		"frame start did not request both codes")

endmodule

@@ src/cse_fifo.sv @@
// Short request queue between the front and back of the encoder.
`timescale 1ns / 1ps
`include "cell_to_ansi_sgr_encoder_assert.svh"
module cse_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cse_pkg::cse_req_t push_req,
	output logic              full,
	input  logic              pop,
	output cse_pkg::cse_req_t head,
	output logic              empty
);
	import cse_pkg::*;

	cse_req_t         mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QAW:0]     count_q;

	assign full  = (count_q == QAW'(0) + (QAW+1)'(QDEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`CSE_ASSERT_ALWAYS(a_count_range, count_q <= (QAW+1)'(QDEPTH), "queue count overflow")
	`CSE_ASSERT_ALWAYS(a_no_pop_empty, !(pop && empty), "pop from empty queue")
	`CSE_ASSERT_ALWAYS(a_no_push_full, !(push && full && !pop), "push into full queue")

endmodule

@@ src/cse_back.sv @@
// Back end: walks each request through the escape byte sequence, one byte per cycle while byte_stall is low.
`timescale 1ns / 1ps
`include "cell_to_ansi_sgr_encoder_assert.svh"
module cse_back (
	input  logic              clk,
	input  logic              arst_n,
	input  cse_pkg::cse_req_t head,
	input  logic              empty,
	output logic              pop,
	output logic              byte_valid,
	input  logic              byte_stall,
	output logic [7:0]        out_byte,
	output logic              last_of_cell
);
	import cse_pkg::*;

	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_ESC  = 11'b000_0000_0010,
		ST_LBR  = 11'b000_0000_0100,
		ST_BG1  = 11'b000_0000_1000,
		ST_BG2  = 11'b000_0001_0000,
		ST_BG3  = 11'b000_0010_0000,
		ST_SEMI = 11'b000_0100_0000,
		ST_FG1  = 11'b000_1000_0000,
		ST_FG2  = 11'b001_0000_0000,
		ST_END  = 11'b010_0000_0000,
		ST_CHR  = 11'b100_0000_0000
	} cse_state_t;

	cse_state_t state_q;
	cse_req_t   cur_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	cse_req_t   sel;
	cse_state_t sel_state;
	cse_state_t head_start;
	cse_state_t nxt;
	cse_state_t after_bg;
	logic [7:0] emit_byte;
	logic       emit_last;
	logic       adv;
	logic       have;
	logic       idle;

	assign idle       = (state_q == ST_IDLE);
	assign adv        = ~out_valid_q | ~byte_stall;
	assign have       = ~idle | ~empty;
	assign head_start = head.esc ? ST_ESC : ST_CHR;
	assign sel        = idle ? head : cur_q;
	assign sel_state  = idle ? head_start : state_q;
	assign after_bg   = sel.fg_chg ? ST_SEMI : ST_END;

	// take the next request when idle, or straight after a character byte
	assign pop = adv & ~empty & (idle | (sel_state == ST_CHR));

	always_comb begin
		emit_last = 1'b0;
		emit_byte = sel.ch;
		nxt       = ST_IDLE;
		unique case (sel_state)
			ST_ESC: begin
				emit_byte = ESC_CHAR;
				nxt       = ST_LBR;
			end
			ST_LBR: begin
				emit_byte = LBRACKET;
				nxt       = sel.bg_chg ? ST_BG1 : (sel.fg_chg ? ST_FG1 : ST_END);
			end
			ST_BG1: begin
				emit_byte = sel.bg[3] ? ASCII_1 : ASCII_4;
				nxt       = ST_BG2;
			end
			ST_BG2: begin
				emit_byte = sel.bg[3] ? ASCII_0 : digit_char(sel.bg[2:0]);
				nxt       = sel.bg[3] ? ST_BG3 : after_bg;
			end
			ST_BG3: begin
				emit_byte = digit_char(sel.bg[2:0]);
				nxt       = after_bg;
			end
			ST_SEMI: begin
				emit_byte = SEMI;
				nxt       = ST_FG1;
			end
			ST_FG1: begin
				emit_byte = sel.fg[3] ? ASCII_9 : ASCII_3;
				nxt       = ST_FG2;
			end
			ST_FG2: begin
				emit_byte = digit_char(sel.fg[2:0]);
				nxt       = ST_END;
			end
			ST_END: begin
				emit_byte = SGR_END;
				nxt       = ST_CHR;
			end
			ST_CHR: begin
				emit_byte = sel.ch;
				emit_last = 1'b1;
				nxt       = ST_IDLE;
			end
			default: begin
				emit_byte = sel.ch;
				nxt       = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= have;
			if (have) begin
				if (idle) begin
					state_q <= nxt;
				end else if (sel_state == ST_CHR) begin
					state_q <= empty ? ST_IDLE : head_start;
				end else begin
					state_q <= nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && have) begin
			out_byte_q <= emit_byte;
			out_last_q <= emit_last;
		end
		if (pop) begin
			cur_q <= head;
		end
	end

	assign byte_valid   = out_valid_q;
	assign out_byte     = out_byte_q;
	assign last_of_cell = out_last_q;

	`CSE_ASSERT_NEXT(a_esc_then_bracket,
		out_valid_q && !byte_stall && !out_last_q && out_byte_q == ESC_CHAR,
		out_valid_q && out_byte_q == LBRACKET && !out_last_q, "ESC not followed by bracket")
	`CSE_ASSERT_NEXT(a_end_then_char,
		out_valid_q && !byte_stall && !out_last_q && out_byte_q == SGR_END,
		out_valid_q && out_last_q, "SGR terminator not followed by character")
	`CSE_ASSERT_ALWAYS(a_busy_when_mid_cell, !(out_valid_q && !out_last_q && idle),
		"sequencer idle with an escape unfinished")

endmodule

@@ src/cell_to_ansi_sgr_encoder.sv @@
// Top level of the ANSI SGR colour escape encoder for text cells.
//
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------
//  cell    | cell_valid/cell_stall  | frame_start, colour, character
//  byte    | byte_valid/byte_stall  | out_byte, last_of_cell
//
// One cell per cycle is taken while the four-entry request queue has room.
// Each cell yields 1 to 10 output bytes; the back sequencer emits one byte per
// cycle while byte_stall is low, with cells back to back.
// arst_n clears colour tracking (next cell is a frame start), queue and sequencer.
// byte_stall holds the output register; cell_stall rises only when the queue is full.
`timescale 1ns / 1ps
module cell_to_ansi_sgr_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cell_valid,
	output logic       cell_stall,
	input  logic       frame_start,
	input  logic [7:0] colour,
	input  logic [7:0] character,
	output logic       byte_valid,
	input  logic       byte_stall,
	output logic [7:0] out_byte,
	output logic       last_of_cell
);
	import cse_pkg::*;

	cse_req_t push_req;
	cse_req_t head;
	logic     push;
	logic     full;
	logic     pop;
	logic     empty;

	cse_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cell_valid  (cell_valid),
		.cell_stall  (cell_stall),
		.frame_start (frame_start),
		.colour      (colour),
		.character   (character),
		.q_full      (full),
		.q_push      (push),
		.q_req       (push_req)
	);

	cse_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_req (push_req),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	cse_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.out_byte     (out_byte),
		.last_of_cell (last_of_cell)
	);

endmodule

@@ tb/cell_to_ansi_sgr_encoder_tb.sv @@
// Self-checking testbench for the ANSI SGR cell encoder: directed and random cells, random stalls, byte check.
`timescale 1ns / 1ps
module cell_to_ansi_sgr_encoder_tb;
	import cse_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 300000;
	localparam int unsigned RANDOM_CELLS = 270;

	typedef struct {
		bit          frame_start;
		bit [7:0]    colour;
		bit [7:0]    character;
		bit          hold_drain;
		int unsigned gap;
	} cell_req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} sgr_byte_t;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       cell_valid   = 1'b0;
	logic       frame_start  = 1'b0;
	logic [7:0] colour       = 8'h00;
	logic [7:0] character    = 8'h00;
	logic       byte_stall   = 1'b0;
	logic       cell_stall;
	logic       byte_valid;
	logic [7:0] out_byte;
	logic       last_of_cell;

	cell_req_t   pending_cells[$];
	sgr_byte_t   sgr_expect[$];
	cell_req_t   cur_cell;
	cell_req_t   next_cell;
	bit          have_next    = 1'b0;
	int unsigned gap_left     = 0;
	int unsigned stall_left   = 0;
	int unsigned bytes_seen   = 0;
	int unsigned mismatches   = 0;
	int unsigned cycles       = 0;

	// tracked terminal state
	bit       trk_fresh;
	bit [7:0] trk_colour;
	bit [3:0] trk_bg;
	bit [3:0] trk_fg;

	cell_to_ansi_sgr_encoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cell_valid   (cell_valid),
		.cell_stall   (cell_stall),
		.frame_start  (frame_start),
		.colour       (colour),
		.character    (character),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.out_byte     (out_byte),
		.last_of_cell (last_of_cell)
	);

	always #1 clk = ~clk;

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	function automatic void push_byte(input logic [7:0] b, input logic last);
		sgr_byte_t e;
		e.out_byte = b;
		e.last     = last;
		sgr_expect.insert(sgr_expect.size(), e);
	endfunction

	function automatic void push_code(input bit [3:0] idx, input bit is_bg);
		if (idx < 4'd8) begin
			push_byte(is_bg ? ASCII_4 : ASCII_3, 1'b0);
			push_byte(ASCII_0 + {5'b0, idx[2:0]}, 1'b0);
		end else if (is_bg) begin
			push_byte(ASCII_1, 1'b0);
			push_byte(ASCII_0, 1'b0);
			push_byte(ASCII_0 + {5'b0, idx[2:0]}, 1'b0);
		end else begin
			push_byte(ASCII_9, 1'b0);
			push_byte(ASCII_0 + {5'b0, idx[2:0]}, 1'b0);
		end
	endfunction

	// Append the byte stream one cell produces and advance the tracked state
	function automatic void encode_cell(input cell_req_t c);
		bit       first;
		bit [3:0] bg;
		bit [3:0] fg;
		bit       bg_chg;
		bit       fg_chg;
		first = c.frame_start || trk_fresh;
		bg    = c.colour[7:4];
		fg    = c.colour[3:0];
		if (first || c.colour != trk_colour) begin
			bg_chg = first || bg != trk_bg;
			fg_chg = first || fg != trk_fg;
			push_byte(ESC_CHAR, 1'b0);
			push_byte(LBRACKET, 1'b0);
			if (bg_chg) begin
				push_code(bg, 1'b1);
				trk_bg = bg;
			end
			if (bg_chg && fg_chg)
				push_byte(SEMI, 1'b0);
			if (fg_chg) begin
				push_code(fg, 1'b0);
				trk_fg = fg;
			end
			push_byte(SGR_END, 1'b0);
			trk_colour = c.colour;
		end
		push_byte(c.character != 8'h00 ? c.character : BLANK, 1'b1);
		trk_fresh = 1'b0;
	endfunction

	function automatic void add_cell(input bit fs, input bit [7:0] col, input bit [7:0] ch,
			input int unsigned gap, input bit drain);
		cell_req_t c;
		c.frame_start = fs;
		c.colour      = col;
		c.character   = ch;
		c.gap         = gap;
		c.hold_drain  = drain;
		pending_cells.insert(pending_cells.size(), c);
	endfunction

	// Cell driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_valid  <= 1'b0;
			frame_start <= 1'b0;
			colour      <= 8'h00;
			character   <= 8'h00;
			have_next   = 1'b0;
			gap_left    = 0;
			trk_fresh   = 1'b1;
			trk_colour  = 8'h00;
			trk_bg      = 4'h0;
			trk_fg      = 4'h0;
		end else begin : drive
			logic nv;
			nv = cell_valid;
			if (cell_valid && !cell_stall) begin
				encode_cell(cur_cell);
				nv = 1'b0;
			end
			if (!nv) begin
				if (!have_next && pending_cells.size() > 0) begin
					next_cell = pending_cells.pop_front();
					have_next = 1'b1;
					gap_left  = next_cell.gap;
				end
				if (have_next) begin
					if (gap_left > 0) begin
						gap_left--;
					end else if (!next_cell.hold_drain || sgr_expect.size() == 0) begin
						cur_cell    = next_cell;
						have_next   = 1'b0;
						frame_start <= next_cell.frame_start;
						colour      <= next_cell.colour;
						character   <= next_cell.character;
						nv = 1'b1;
					end
				end
			end
			cell_valid <= nv;
		end
	end

	// Byte monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_stall <= 1'b0;
			stall_left = 0;
		end else begin : watch
			sgr_byte_t e;
			if (byte_valid && !byte_stall) begin
				if (sgr_expect.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %h last %b", out_byte,
						last_of_cell));
				end else begin
					e = sgr_expect.pop_front();
					if (out_byte !== e.out_byte)
						report_mismatch($sformatf("byte %0d: out_byte %h, want %h",
							bytes_seen, out_byte, e.out_byte));
					if (last_of_cell !== e.last)
						report_mismatch($sformatf("byte %0d: last_of_cell %b, want %b",
							bytes_seen, last_of_cell, e.last));
				end
				bytes_seen++;
				// every fourth stretch of 64 bytes runs without back-pressure
				stall_left = (((bytes_seen >> 6) % 4) == 3) ? 0 : $urandom_range(0, 10);
			end
			if (stall_left > 0) begin
				stall_left--;
				byte_stall <= 1'b1;
			end else begin
				byte_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin : stimulus
		bit [7:0]    gen_colour;
		bit [7:0]    ch;
		bit          fs;
		int unsigned r;
		int unsigned gap;

		// directed cells
		add_cell(1'b0, 8'h00, 8'h41, $urandom_range(0, 10), 1'b0); // first cell after reset
		add_cell(1'b0, 8'h00, 8'h42, $urandom_range(0, 10), 1'b0); // same colour
		add_cell(1'b0, 8'h07, 8'h00, $urandom_range(0, 10), 1'b0); // foreground only, blank
		add_cell(1'b0, 8'h77, 8'h43, $urandom_range(0, 10), 1'b0); // background only
		add_cell(1'b0, 8'h8F, 8'hFF, $urandom_range(0, 10), 1'b0); // both, bright codes
		add_cell(1'b1, 8'h8F, 8'h01, $urandom_range(0, 10), 1'b0); // frame start, same colour
		add_cell(1'b0, 8'hF8, 8'h80, $urandom_range(0, 10), 1'b0);
		add_cell(1'b0, 8'hF0, 8'h7F, $urandom_range(0, 10), 1'b0);
		add_cell(1'b0, 8'h00, 8'h20, $urandom_range(0, 10), 1'b0);
		add_cell(1'b0, 8'hFF, 8'h00, $urandom_range(0, 10), 1'b0);
		add_cell(1'b1, 8'hFF, 8'h00, 0, 1'b0);
		add_cell(1'b0, 8'h0F, 8'h20, 0, 1'b0);
		add_cell(1'b0, 8'hF0, 8'hFE, 0, 1'b0);
		add_cell(1'b1, 8'h5A, 8'hAA, 0, 1'b1);                    // wait for drain
		add_cell(1'b0, 8'hA5, 8'h55, 0, 1'b0);
		add_cell(1'b0, 8'hA5, 8'h00, 0, 1'b0);
		add_cell(1'b1, 8'h00, 8'h00, $urandom_range(0, 10), 1'b0);

		// random cells, mostly small colour steps so unchanged codes stay common
		gen_colour = 8'h00;
		for (int unsigned i = 0; i < RANDOM_CELLS; i++) begin
			r = $urandom_range(0, 99);
			if (r < 30)
				gen_colour = gen_colour;
			else if (r < 50)
				gen_colour[7:4] = 4'($urandom_range(0, 15));
			else if (r < 70)
				gen_colour[3:0] = 4'($urandom_range(0, 15));
			else
				gen_colour = 8'($urandom_range(0, 255));
			fs  = ($urandom_range(0, 15) == 0);
			ch  = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
			gap = (((i / 40) % 3) == 2) ? 0 : $urandom_range(0, 10);
			add_cell(fs, gen_colour, ch, gap, (i == 120 || i == 200));
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_cells.size() > 0 || have_next || cell_valid || sgr_expect.size() > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		if (mismatches == 0 && sgr_expect.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
